// ----- src/lmap_pkg.sv -----
`timescale 1ns / 1ps

package lmap_pkg;

    // divider: one quotient bit per stage, plus an entry and an exit stage
    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    // third radial coefficient, signed q8.24
    localparam logic signed [31:0] RADIAL_K3 = 32'sd0;

    localparam logic signed [39:0] Q_ONE  = 40'sh00_0100_0000;
    localparam logic signed [39:0] S32_MAX = 40'sh00_7FFF_FFFF;
    localparam logic signed [39:0] S32_MIN = -40'sh00_8000_0000;

    // register map, word index
    typedef enum logic [2:0] {
        REG_FOCAL_X = 3'd0,
        REG_FOCAL_Y = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_RADIAL_K1 = 3'd4,
        REG_RADIAL_K2 = 3'd5,
        REG_TANGENTIAL_P1 = 3'd6,
        REG_TANGENTIAL_P2 = 3'd7
    } reg_idx_t;

    // saturated q8.24 value with its overflow mark
    typedef struct packed {
        logic               ov;
        logic signed [31:0] val;
    } qval_t;

    function automatic qval_t sat32(input logic signed [39:0] v);
        qval_t r;
        r.ov  = 1'b0;
        r.val = v[31:0];
        if (v > S32_MAX) begin
            r.ov  = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            r.ov  = 1'b1;
            r.val = 32'sh8000_0000;
        end
        return r;
    endfunction

    // q8.24 product, round half up, saturated
    function automatic qval_t qmul(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        p = p + 64'sh0000_0000_0080_0000;
        return sat32(p[63:24]);
    endfunction

    function automatic logic signed [39:0] ext40(input logic signed [31:0] v);
        return 40'(v);
    endfunction

endpackage

// ----- src/lmap_div.sv -----
`timescale 1ns / 1ps

module lmap_div import lmap_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [24:0] dx,
    input  logic [22:0]        focal,
    output logic signed [31:0] quo,
    output logic               ovf
);

    logic [22:0]          rem_reg  [0:DIV_STEPS];
    logic [22:0]          rem_next [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg    [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] q_next   [0:DIV_STEPS];
    logic [7:0]           frac_reg [0:DIV_STEPS];
    logic [7:0]           frac_next[0:DIV_STEPS];
    logic                 neg_reg  [0:DIV_STEPS];
    logic                 neg_next [0:DIV_STEPS];
    logic                 big_reg  [0:DIV_STEPS];
    logic                 big_next [0:DIV_STEPS];
    logic signed [31:0]   quo_reg, quo_next;
    logic                 ovf_reg, ovf_next;
    logic [24:0]          mag;
    logic [23:0]          trial;

    // entry stage and one restoring step per stage
    always_comb begin
        mag = dx[24] ? 25'(-dx) : 25'(dx);
        neg_next[0]  = dx[24];
        big_next[0]  = {7'd0, mag[23:8]} >= focal;
        rem_next[0]  = {7'd0, mag[23:8]};
        frac_next[0] = mag[7:0];
        q_next[0]    = '0;
        trial        = '0;
        for (int j = 0; j < DIV_STEPS; j++) begin
            trial = {rem_reg[j], frac_reg[j][7]};
            if (trial >= {1'b0, focal}) begin
                rem_next[j+1] = 23'(trial - {1'b0, focal});
                q_next[j+1]   = {q_reg[j][DIV_STEPS-2:0], 1'b1};
            end else begin
                rem_next[j+1] = trial[22:0];
                q_next[j+1]   = {q_reg[j][DIV_STEPS-2:0], 1'b0};
            end
            frac_next[j+1] = {frac_reg[j][6:0], 1'b0};
            neg_next[j+1]  = neg_reg[j];
            big_next[j+1]  = big_reg[j];
        end
    end

    // sign and saturation on exit
    always_comb begin
        ovf_next = 1'b0;
        if (big_reg[DIV_STEPS]) begin
            ovf_next = 1'b1;
            quo_next = neg_reg[DIV_STEPS] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (neg_reg[DIV_STEPS]) begin
            if (q_reg[DIV_STEPS] > 32'h8000_0000) begin
                ovf_next = 1'b1;
                quo_next = 32'sh8000_0000;
            end else begin
                quo_next = -$signed(q_reg[DIV_STEPS]);
            end
        end else if (q_reg[DIV_STEPS][31]) begin
            ovf_next = 1'b1;
            quo_next = 32'sh7FFF_FFFF;
        end else begin
            quo_next = $signed(q_reg[DIV_STEPS]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j <= DIV_STEPS; j++) begin
                rem_reg[j]  <= rem_next[j];
                q_reg[j]    <= q_next[j];
                frac_reg[j] <= frac_next[j];
                neg_reg[j]  <= neg_next[j];
                big_reg[j]  <= big_next[j];
            end
            quo_reg <= quo_next;
            ovf_reg <= ovf_next;
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_reg;

endmodule

// ----- src/lens_distortion_point_mapper_top.sv -----
`timescale 1ns / 1ps
// pipeline: 34 divider stages, 9 math stages and one output stage lie between input beat and
// result beat
// throughput: one point per cycle; a stalled output holds the whole pipeline
// the divider is fully pipelined, one quotient bit per stage for x and y in parallel
// reset (aresetn low, synchronous) clears all valid bits and loads register defaults
// configuration registers are read live; write them only while the pipeline is empty

module lens_distortion_point_mapper_top import lmap_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // point_x [23:0], point_y [47:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // warped_x [23:0], warped_y [47:24]
    output logic        m_tuser,   // overflow [0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [22:0]        focal_x_reg, focal_y_reg;
    logic signed [23:0] center_x_reg, center_y_reg;
    logic signed [31:0] k1_reg, k2_reg, p1_reg, p2_reg;
    reg_idx_t           idx;
    logic [22:0]        fx_use, fy_use;

    // configuration port
    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg  <= 23'd256;
            focal_y_reg  <= 23'd256;
            center_x_reg <= '0;
            center_y_reg <= '0;
            k1_reg       <= '0;
            k2_reg       <= '0;
            p1_reg       <= '0;
            p2_reg       <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_FOCAL_X:       focal_x_reg  <= pwdata[22:0];
                REG_FOCAL_Y:       focal_y_reg  <= pwdata[22:0];
                REG_CENTER_X:      center_x_reg <= pwdata[23:0];
                REG_CENTER_Y:      center_y_reg <= pwdata[23:0];
                REG_RADIAL_K1:     k1_reg       <= pwdata;
                REG_RADIAL_K2:     k2_reg       <= pwdata;
                REG_TANGENTIAL_P1: p1_reg       <= pwdata;
                REG_TANGENTIAL_P2: p2_reg       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FOCAL_X:       prdata = {9'd0, focal_x_reg};
            REG_FOCAL_Y:       prdata = {9'd0, focal_y_reg};
            REG_CENTER_X:      prdata = {8'd0, center_x_reg};
            REG_CENTER_Y:      prdata = {8'd0, center_y_reg};
            REG_RADIAL_K1:     prdata = k1_reg;
            REG_RADIAL_K2:     prdata = k2_reg;
            REG_TANGENTIAL_P1: prdata = p1_reg;
            REG_TANGENTIAL_P2: prdata = p2_reg;
            default:           prdata = '0;
        endcase
    end

    // zero focal length acts as one lsb
    assign fx_use = (focal_x_reg == '0) ? 23'd1 : focal_x_reg;
    assign fy_use = (focal_y_reg == '0) ? 23'd1 : focal_y_reg;

    // pipeline advance
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // normalization dividers
    logic signed [24:0] dx, dy;
    logic signed [31:0] qx, qy;
    logic               ovx, ovy;
    logic [DIV_LAT-1:0] dv_reg;

    assign dx = 25'($signed(s_tdata[23:0])) - 25'(center_x_reg);
    assign dy = 25'($signed(s_tdata[47:24])) - 25'(center_y_reg);

    lmap_div u_div_x (.aclk(aclk), .en(en), .dx(dx), .focal(fx_use), .quo(qx), .ovf(ovx));
    lmap_div u_div_y (.aclk(aclk), .en(en), .dx(dy), .focal(fy_use), .quo(qy), .ovf(ovy));

    // valid bits of math stages 1..9
    logic [9:1] v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg       <= '0;
            v_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            dv_reg       <= {dv_reg[DIV_LAT-2:0], s_tvalid};
            v_reg        <= {v_reg[8:1], dv_reg[DIV_LAT-1]};
            m_tvalid_reg <= v_reg[9];
        end
    end

    // stage 1: squares and cross product
    logic signed [31:0] s1_x_reg, s1_y_reg, s1_x2_reg, s1_y2_reg, s1_xy_reg;
    logic               s1_ov_reg;
    qval_t              s1_x2_next, s1_y2_next, s1_xy_next;
    always_comb begin
        s1_x2_next = qmul(qx, qx);
        s1_y2_next = qmul(qy, qy);
        s1_xy_next = qmul(qx, qy);
    end

    // stage 2: r squared
    logic signed [31:0] s2_x_reg, s2_y_reg, s2_x2_reg, s2_y2_reg, s2_xy_reg, s2_r2_reg;
    logic               s2_ov_reg;
    qval_t              s2_r2_next;
    always_comb s2_r2_next = sat32(ext40(s1_x2_reg) + ext40(s1_y2_reg));

    // stage 3: r^4, k1 term, tangential sums
    logic signed [31:0] s3_x_reg, s3_y_reg, s3_xy_reg, s3_r2_reg, s3_r4_reg, s3_k1r2_reg;
    logic signed [31:0] s3_tx_reg, s3_ty_reg;
    logic               s3_ov_reg;
    qval_t              s3_r4_next, s3_k1r2_next, s3_tx_next, s3_ty_next;
    always_comb begin
        s3_r4_next   = qmul(s2_r2_reg, s2_r2_reg);
        s3_k1r2_next = qmul(k1_reg, s2_r2_reg);
        s3_tx_next   = sat32(ext40(s2_r2_reg) + (ext40(s2_x2_reg) <<< 1));
        s3_ty_next   = sat32(ext40(s2_r2_reg) + (ext40(s2_y2_reg) <<< 1));
    end

    // stage 4: r^6, k2 term, tangential products
    logic signed [31:0] s4_x_reg, s4_y_reg, s4_k1r2_reg, s4_r6_reg, s4_k2r4_reg;
    logic signed [31:0] s4_p1xy_reg, s4_p2xy_reg, s4_p2tx_reg, s4_p1ty_reg;
    logic               s4_ov_reg;
    qval_t              s4_r6_next, s4_k2r4_next, s4_p1xy_next, s4_p2xy_next;
    qval_t              s4_p2tx_next, s4_p1ty_next;
    always_comb begin
        s4_r6_next   = qmul(s3_r4_reg, s3_r2_reg);
        s4_k2r4_next = qmul(k2_reg, s3_r4_reg);
        s4_p1xy_next = qmul(p1_reg, s3_xy_reg);
        s4_p2xy_next = qmul(p2_reg, s3_xy_reg);
        s4_p2tx_next = qmul(p2_reg, s3_tx_reg);
        s4_p1ty_next = qmul(p1_reg, s3_ty_reg);
    end

    // stage 5: k3 term
    logic signed [31:0] s5_x_reg, s5_y_reg, s5_k1r2_reg, s5_k2r4_reg, s5_k3r6_reg;
    logic signed [31:0] s5_p1xy_reg, s5_p2xy_reg, s5_p2tx_reg, s5_p1ty_reg;
    logic               s5_ov_reg;
    qval_t              s5_k3r6_next;
    always_comb s5_k3r6_next = qmul(RADIAL_K3, s4_r6_reg);

    // stage 6: radial factor
    logic signed [31:0] s6_x_reg, s6_y_reg, s6_rad_reg;
    logic signed [31:0] s6_p1xy_reg, s6_p2xy_reg, s6_p2tx_reg, s6_p1ty_reg;
    logic               s6_ov_reg;
    qval_t              s6_rad_next;
    always_comb s6_rad_next = sat32(Q_ONE + ext40(s5_k1r2_reg) + ext40(s5_k2r4_reg)
                                    + ext40(s5_k3r6_reg));

    // stage 7: radial scaling
    logic signed [31:0] s7_xrad_reg, s7_yrad_reg;
    logic signed [31:0] s7_p1xy_reg, s7_p2xy_reg, s7_p2tx_reg, s7_p1ty_reg;
    logic               s7_ov_reg;
    qval_t              s7_xrad_next, s7_yrad_next;
    always_comb begin
        s7_xrad_next = qmul(s6_x_reg, s6_rad_reg);
        s7_yrad_next = qmul(s6_y_reg, s6_rad_reg);
    end

    // stage 8: distorted normalized point
    logic signed [31:0] s8_xd_reg, s8_yd_reg;
    logic               s8_ov_reg;
    qval_t              s8_xd_next, s8_yd_next;
    always_comb begin
        s8_xd_next = sat32(ext40(s7_xrad_reg) + (ext40(s7_p1xy_reg) <<< 1)
                           + ext40(s7_p2tx_reg));
        s8_yd_next = sat32(ext40(s7_yrad_reg) + ext40(s7_p1ty_reg)
                           + (ext40(s7_p2xy_reg) <<< 1));
    end

    // stage 9: scale back by focal length
    logic signed [31:0] s9_sx_reg, s9_sy_reg;
    logic               s9_ov_reg;
    logic signed [55:0] s9_px_next, s9_py_next;
    always_comb begin
        s9_px_next = 56'(s8_xd_reg) * 56'($signed({1'b0, fx_use}))
                     + 56'sh00_0000_0080_0000;
        s9_py_next = 56'(s8_yd_reg) * 56'($signed({1'b0, fy_use}))
                     + 56'sh00_0000_0080_0000;
    end

    // output stage: add principal point, clamp to 24 bits
    logic signed [23:0] wx_reg, wy_reg, wx_next, wy_next;
    logic               ov_reg, ov_next;
    logic signed [32:0] ux, uy;
    always_comb begin
        ux      = 33'(s9_sx_reg) + 33'(center_x_reg);
        uy      = 33'(s9_sy_reg) + 33'(center_y_reg);
        ov_next = s9_ov_reg;
        wx_next = ux[23:0];
        wy_next = uy[23:0];
        if (ux > 33'sd8388607) begin
            wx_next = 24'sh7F_FFFF;
            ov_next = 1'b1;
        end else if (ux < -33'sd8388608) begin
            wx_next = 24'sh80_0000;
            ov_next = 1'b1;
        end
        if (uy > 33'sd8388607) begin
            wy_next = 24'sh7F_FFFF;
            ov_next = 1'b1;
        end else if (uy < -33'sd8388608) begin
            wy_next = 24'sh80_0000;
            ov_next = 1'b1;
        end
    end

    // math stage registers
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_x_reg  <= qx;
            s1_y_reg  <= qy;
            s1_x2_reg <= s1_x2_next.val;
            s1_y2_reg <= s1_y2_next.val;
            s1_xy_reg <= s1_xy_next.val;
            s1_ov_reg <= ovx | ovy | s1_x2_next.ov | s1_y2_next.ov | s1_xy_next.ov;

            s2_x_reg  <= s1_x_reg;
            s2_y_reg  <= s1_y_reg;
            s2_x2_reg <= s1_x2_reg;
            s2_y2_reg <= s1_y2_reg;
            s2_xy_reg <= s1_xy_reg;
            s2_r2_reg <= s2_r2_next.val;
            s2_ov_reg <= s1_ov_reg | s2_r2_next.ov;

            s3_x_reg    <= s2_x_reg;
            s3_y_reg    <= s2_y_reg;
            s3_xy_reg   <= s2_xy_reg;
            s3_r2_reg   <= s2_r2_reg;
            s3_r4_reg   <= s3_r4_next.val;
            s3_k1r2_reg <= s3_k1r2_next.val;
            s3_tx_reg   <= s3_tx_next.val;
            s3_ty_reg   <= s3_ty_next.val;
            s3_ov_reg   <= s2_ov_reg | s3_r4_next.ov | s3_k1r2_next.ov
                           | s3_tx_next.ov | s3_ty_next.ov;

            s4_x_reg    <= s3_x_reg;
            s4_y_reg    <= s3_y_reg;
            s4_k1r2_reg <= s3_k1r2_reg;
            s4_r6_reg   <= s4_r6_next.val;
            s4_k2r4_reg <= s4_k2r4_next.val;
            s4_p1xy_reg <= s4_p1xy_next.val;
            s4_p2xy_reg <= s4_p2xy_next.val;
            s4_p2tx_reg <= s4_p2tx_next.val;
            s4_p1ty_reg <= s4_p1ty_next.val;
            s4_ov_reg   <= s3_ov_reg | s4_r6_next.ov | s4_k2r4_next.ov | s4_p1xy_next.ov
                           | s4_p2xy_next.ov | s4_p2tx_next.ov | s4_p1ty_next.ov;

            s5_x_reg    <= s4_x_reg;
            s5_y_reg    <= s4_y_reg;
            s5_k1r2_reg <= s4_k1r2_reg;
            s5_k2r4_reg <= s4_k2r4_reg;
            s5_k3r6_reg <= s5_k3r6_next.val;
            s5_p1xy_reg <= s4_p1xy_reg;
            s5_p2xy_reg <= s4_p2xy_reg;
            s5_p2tx_reg <= s4_p2tx_reg;
            s5_p1ty_reg <= s4_p1ty_reg;
            s5_ov_reg   <= s4_ov_reg | s5_k3r6_next.ov;

            s6_x_reg    <= s5_x_reg;
            s6_y_reg    <= s5_y_reg;
            s6_rad_reg  <= s6_rad_next.val;
            s6_p1xy_reg <= s5_p1xy_reg;
            s6_p2xy_reg <= s5_p2xy_reg;
            s6_p2tx_reg <= s5_p2tx_reg;
            s6_p1ty_reg <= s5_p1ty_reg;
            s6_ov_reg   <= s5_ov_reg | s6_rad_next.ov;

            s7_xrad_reg <= s7_xrad_next.val;
            s7_yrad_reg <= s7_yrad_next.val;
            s7_p1xy_reg <= s6_p1xy_reg;
            s7_p2xy_reg <= s6_p2xy_reg;
            s7_p2tx_reg <= s6_p2tx_reg;
            s7_p1ty_reg <= s6_p1ty_reg;
            s7_ov_reg   <= s6_ov_reg | s7_xrad_next.ov | s7_yrad_next.ov;

            s8_xd_reg <= s8_xd_next.val;
            s8_yd_reg <= s8_yd_next.val;
            s8_ov_reg <= s7_ov_reg | s8_xd_next.ov | s8_yd_next.ov;

            s9_sx_reg <= s9_px_next[55:24];
            s9_sy_reg <= s9_py_next[55:24];
            s9_ov_reg <= s8_ov_reg;

            wx_reg <= wx_next;
            wy_reg <= wy_next;
            ov_reg <= ov_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {wy_reg, wx_reg};
    assign m_tuser  = ov_reg;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import lmap_pkg::*;

    typedef struct packed {
        logic signed [23:0] py;
        logic signed [23:0] px;
    } point_t;

    typedef struct packed {
        logic               ovf;
        logic signed [23:0] wy;
        logic signed [23:0] wx;
    } warp_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // point_x [23:0], point_y [47:24]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // warped_x [23:0], warped_y [47:24]
    logic        m_tuser;   // overflow [0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    point_t      point_pending_q[$];
    warp_t       warp_expected_q[$];
    logic [31:0] cfg_mirror[8];
    int          error_count;
    bit          beat_taken;
    bit          hold_send;
    int          gap_left;
    int          burst_left;
    int          stall_mode;
    int          stall_count;

    lens_distortion_point_mapper_top dut (.*);

    // clock
    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic longint clip(longint v, longint lo, longint hi, inout bit ovf);
        if (v > hi) begin
            ovf = 1'b1;
            return hi;
        end
        if (v < lo) begin
            ovf = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic longint clip32(longint v, inout bit ovf);
        return clip(v, -64'sd2147483648, 64'sd2147483647, ovf);
    endfunction

    // q8.24 product, round half up
    function automatic longint qprod(longint a, longint b, inout bit ovf);
        return clip32((a * b + (64'sd1 <<< 23)) >>> 24, ovf);
    endfunction

    function automatic warp_t predict_warp(point_t pt);
        warp_t  r;
        bit     ovf;
        longint fx, fy, cx, cy, k1, k2, k3, p1, p2;
        longint x, y, x2, y2, xy, r2, r4, r6, rad, xd, yd, t, u, v;
        ovf = 1'b0;
        fx  = longint'(cfg_mirror[REG_FOCAL_X][22:0]);
        fy  = longint'(cfg_mirror[REG_FOCAL_Y][22:0]);
        cx  = longint'($signed(cfg_mirror[REG_CENTER_X][23:0]));
        cy  = longint'($signed(cfg_mirror[REG_CENTER_Y][23:0]));
        k1  = longint'($signed(cfg_mirror[REG_RADIAL_K1]));
        k2  = longint'($signed(cfg_mirror[REG_RADIAL_K2]));
        p1  = longint'($signed(cfg_mirror[REG_TANGENTIAL_P1]));
        p2  = longint'($signed(cfg_mirror[REG_TANGENTIAL_P2]));
        k3  = longint'(RADIAL_K3);
        // a zero focal length counts as one lsb
        if (fx == 0) fx = 1;
        if (fy == 0) fy = 1;
        x   = clip32(((longint'(pt.px) - cx) <<< 24) / fx, ovf);
        y   = clip32(((longint'(pt.py) - cy) <<< 24) / fy, ovf);
        x2  = qprod(x, x, ovf);
        y2  = qprod(y, y, ovf);
        xy  = qprod(x, y, ovf);
        r2  = clip32(x2 + y2, ovf);
        r4  = qprod(r2, r2, ovf);
        r6  = qprod(r4, r2, ovf);
        rad = clip32((64'sd1 <<< 24) + qprod(k1, r2, ovf) + qprod(k2, r4, ovf)
                     + qprod(k3, r6, ovf), ovf);
        t   = clip32(r2 + 2 * x2, ovf);
        xd  = clip32(qprod(x, rad, ovf) + 2 * qprod(p1, xy, ovf) + qprod(p2, t, ovf), ovf);
        t   = clip32(r2 + 2 * y2, ovf);
        yd  = clip32(qprod(y, rad, ovf) + qprod(p1, t, ovf) + 2 * qprod(p2, xy, ovf), ovf);
        u   = clip(((xd * fx + (64'sd1 <<< 23)) >>> 24) + cx, -64'sd8388608, 64'sd8388607, ovf);
        v   = clip(((yd * fy + (64'sd1 <<< 23)) >>> 24) + cy, -64'sd8388608, 64'sd8388607, ovf);
        r.wx  = u[23:0];
        r.wy  = v[23:0];
        r.ovf = ovf;
        return r;
    endfunction

    // input beats feed the predictor, result beats are checked against it
    always @(posedge aclk) begin
        warp_t got;
        warp_t want;
        beat_taken = aresetn && s_tvalid && s_tready;
        if (beat_taken)
            warp_expected_q.insert(warp_expected_q.size(), predict_warp(point_t'(s_tdata)));
        if (aresetn && m_tvalid && m_tready) begin
            got.wx  = m_tdata[23:0];
            got.wy  = m_tdata[47:24];
            got.ovf = m_tuser;
            if (warp_expected_q.size() == 0) begin
                error_count++;
                $display("%0t result beat: expected none actual %h", $time, got);
            end else begin
                want = warp_expected_q.pop_front();
                if (got.wx !== want.wx) begin
                    error_count++;
                    $display("%0t warped_x: expected %h actual %h", $time, want.wx, got.wx);
                end
                if (got.wy !== want.wy) begin
                    error_count++;
                    $display("%0t warped_y: expected %h actual %h", $time, want.wy, got.wy);
                end
                if (got.ovf !== want.ovf) begin
                    error_count++;
                    $display("%0t overflow: expected %b actual %b", $time, want.ovf, got.ovf);
                end
            end
        end
    end

    // point driver, bursts with random gaps
    always @(negedge aclk) begin
        point_t pt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !beat_taken) begin
            // hold the beat until taken
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (!hold_send && point_pending_q.size() > 0) begin
            pt = point_pending_q.pop_front();
            s_tdata  <= pt;
            s_tvalid <= 1'b1;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
                burst_left--;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result stalls, in a pattern picked at random from four and renewed when stall_count runs out
    always @(negedge aclk) begin
        if (stall_count == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_count = 64;
        end
        stall_count--;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_count % 16) < 11;
        endcase
    end

    task automatic wait_idle();
        while (point_pending_q.size() > 0 || s_tvalid || warp_expected_q.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx) inside
            REG_FOCAL_X, REG_FOCAL_Y:   cfg_mirror[idx] = val & 32'h007F_FFFF;
            REG_CENTER_X, REG_CENTER_Y: cfg_mirror[idx] = val & 32'h00FF_FFFF;
            default:                    cfg_mirror[idx] = val;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_cfg(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx, logic [31:0] cy,
                            logic [31:0] k1, logic [31:0] k2, logic [31:0] p1, logic [31:0] p2);
        reg_write(REG_FOCAL_X, fx);
        reg_write(REG_FOCAL_Y, fy);
        reg_write(REG_CENTER_X, cx);
        reg_write(REG_CENTER_Y, cy);
        reg_write(REG_RADIAL_K1, k1);
        reg_write(REG_RADIAL_K2, k2);
        reg_write(REG_TANGENTIAL_P1, p1);
        reg_write(REG_TANGENTIAL_P2, p2);
    endtask

    // mostly points near the principal point, some anywhere
    task automatic queue_points(int count);
        point_t pt;
        int     span;
        repeat (count) begin
            if ($urandom_range(0, 9) < 7) begin
                span  = $urandom_range(0, 1) ? 256 * 1024 : 256 * 64;
                pt.px = 24'($signed(cfg_mirror[REG_CENTER_X][23:0])
                            + $signed($urandom_range(0, 2 * span)) - span);
                pt.py = 24'($signed(cfg_mirror[REG_CENTER_Y][23:0])
                            + $signed($urandom_range(0, 2 * span)) - span);
            end else begin
                pt.px = 24'($urandom);
                pt.py = 24'($urandom);
            end
            point_pending_q.insert(point_pending_q.size(), pt);
        end
    endtask

    function automatic logic [31:0] small_coef();
        return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endfunction

    // stimulus
    initial begin
        point_t pt;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        error_count = 0;
        hold_send   = 1'b0;
        gap_left    = 0;
        burst_left  = 0;
        stall_count = 0;
        cfg_mirror  = '{32'd256, 32'd256, 0, 0, 0, 0, 0, 0};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed extremes with reset defaults, then under a real lens
        for (int i = 0; i < 9; i++) begin
            pt.px = (i % 3 == 0) ? 24'sh800000 : (i % 3 == 1) ? 24'sh7FFFFF : 24'sh0;
            pt.py = (i / 3 == 0) ? 24'sh800000 : (i / 3 == 1) ? 24'sh7FFFFF : 24'sh0;
            point_pending_q.insert(point_pending_q.size(), pt);
        end
        wait_idle();
        load_cfg(800 * 256, 790 * 256, 320 * 256, 240 * 256,
                 32'shFFC0_0000, 32'h0010_0000, 32'h0000_4000, 32'shFFFF_C000);
        point_pending_q.insert(point_pending_q.size(),
                               point_t'({24'sd240 * 256, 24'sd320 * 256}));
        point_pending_q.insert(point_pending_q.size(), point_t'({24'sd0, 24'sd0}));
        point_pending_q.insert(point_pending_q.size(),
                               point_t'({24'sd480 * 256, 24'sd640 * 256}));
        point_pending_q.insert(point_pending_q.size(), point_t'({24'sh7FFFFF, 24'sh800000}));
        queue_points(40);

        // let part of the run go out, then pause sending until the pipeline drains
        while (point_pending_q.size() > 20) @(posedge aclk);
        hold_send = 1'b1;
        while (s_tvalid || warp_expected_q.size() > 0) @(posedge aclk);
        hold_send = 1'b0;
        queue_points(30);
        wait_idle();

        // zero and maximal focal lengths, extreme centers and coefficients
        load_cfg(0, 0, 32'h007F_FFFF, 32'h0080_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_points(30);
        wait_idle();
        load_cfg(32'h007F_FFFF, 32'h007F_FFFF, 32'h0080_0000, 32'h007F_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_points(30);
        wait_idle();

        // random lenses, mostly realistic
        for (int ph = 0; ph < 6; ph++) begin
            if (ph % 3 == 2)
                load_cfg($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
            else
                load_cfg($urandom_range(256 * 100, 256 * 4000),
                         $urandom_range(256 * 100, 256 * 4000),
                         $urandom_range(0, 256 * 2000), $urandom_range(0, 256 * 2000),
                         small_coef(), small_coef(),
                         $signed(small_coef()) >>> 4, $signed(small_coef()) >>> 4);
            queue_points(45);
            wait_idle();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
